### hdl/assert_macros.svh
// Assertion macros for the RTL files (included by ks_engine).
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### hdl/ks_pkg.sv
// ----------------------------------------------------------------------------
// ks_pkg
// Sizes and shared types of the key sorter.
// ----------------------------------------------------------------------------
package ks_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]           addr_t;
    typedef logic [CNT_W-1:0]            cnt_t;

    // One sorted result word handed from the engine to the output stage.
    typedef struct packed {
        key_t key;
        logic final_res;
        logic overflow;
    } res_word_t;

endpackage

### hdl/key_sorter_unit.sv
// ----------------------------------------------------------------------------
// key_sorter_unit
// Collects signed keys and emits them in ascending order at end of set.
// ----------------------------------------------------------------------------
// Keys arrive one word at a time; the word with last set closes the set, and
// the unit then returns every stored key in ascending order, duplicates kept,
// with final_res on the last one. Up to ks_pkg::CAPACITY keys are held in a
// single-port-write, single-port-read RAM kept sorted by in-place insertion;
// keys arriving while the store is full are dropped and overflow is raised on
// every result of that set. Input: a key taken into an empty or full store
// is stored or dropped straight from idle; otherwise input stalls while each
// stored key greater than it moves up one place, one RAM read-compare-write
// per moved entry, and the new key is then written. Output: each result is a
// RAM read, then it is presented until taken downstream; the next set's first
// key is taken after the final result leaves the engine. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module key_sorter_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ks_pkg::key_t         key,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ks_pkg::key_t         sorted_key,
    output logic                 final_res,
    output logic                 overflow
);

    logic              res_valid;
    logic              res_stall;
    ks_pkg::res_word_t res_word;

    logic              out_valid_reg;
    ks_pkg::res_word_t out_word_reg;

    ks_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key       (key),
        .last      (last),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    // Output register is free when empty or being drained this cycle.
    assign res_stall = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && !res_stall)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && !res_stall)
            out_word_reg <= res_word;
    end

    assign out_valid  = out_valid_reg;
    assign sorted_key = out_word_reg.key;
    assign final_res  = out_word_reg.final_res;
    assign overflow   = out_word_reg.overflow;

endmodule

### hdl/ks_engine.sv
// ----------------------------------------------------------------------------
// ks_engine
// Key store and its sequencer: insertion sort in place on a synchronous RAM,
// then an in-order read-out of the stored keys.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ks_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ks_pkg::key_t          key,
    input  logic                  last,
    output logic                  res_valid,
    input  logic                  res_stall,
    output ks_pkg::res_word_t     res_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } state_t;

    localparam ks_pkg::cnt_t CAP_CNT = ks_pkg::cnt_t'(ks_pkg::CAPACITY);

    // Key store: one write port, one read port, registered read data.
    ks_pkg::key_t  mem [ks_pkg::CAPACITY];
    ks_pkg::key_t  rd_data_reg;

    state_t        state_reg, state_next;
    ks_pkg::key_t  key_reg, key_next;
    logic          last_reg, last_next;
    ks_pkg::cnt_t  count_reg, count_next;
    logic          dropped_reg, dropped_next;
    ks_pkg::addr_t pos_reg, pos_next;
    ks_pkg::addr_t idx_reg, idx_next;

    logic          wr_en;
    ks_pkg::addr_t wr_addr;
    ks_pkg::key_t  wr_data;
    logic          rd_en;
    ks_pkg::addr_t rd_addr;
    logic          is_final;
    logic          res_take;

    assign is_final = ({1'b0, idx_reg} == ks_pkg::cnt_t'(count_reg - 1'b1));
    assign res_valid = (state_reg == ST_EMIT_WAIT);
    assign res_take  = res_valid && !res_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    assign res_word.key       = rd_data_reg;
    assign res_word.final_res = is_final;
    assign res_word.overflow  = dropped_reg;

    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = key_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next  = key;
                    last_next = last;
                    idx_next  = '0;
                    if (count_reg == CAP_CNT)
                    begin
                        // Full: drop the key, still close the set on last.
                        dropped_next = 1'b1;
                        if (last)
                            state_next = ST_EMIT_RD;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = key;
                        count_next = ks_pkg::cnt_t'(1);
                        if (last)
                            state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        pos_next   = count_reg[ks_pkg::ADDR_W-1:0];
                        rd_en      = 1'b1;
                        rd_addr    = ks_pkg::addr_t'(count_reg[ks_pkg::ADDR_W-1:0] - 1'b1);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // rd_data_reg holds the entry just below pos_reg.
                if (rd_data_reg > key_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg;
                    wr_data  = rd_data_reg;
                    pos_next = ks_pkg::addr_t'(pos_reg - 1'b1);
                    if (pos_reg == ks_pkg::addr_t'(1))
                        state_next = ST_PLACE;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ks_pkg::addr_t'(pos_reg - ks_pkg::addr_t'(2));
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = key_reg;
                    count_next = ks_pkg::cnt_t'(count_reg + 1'b1);
                    state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = key_reg;
                count_next = ks_pkg::cnt_t'(count_reg + 1'b1);
                state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            end

            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                if (res_take)
                begin
                    if (is_final)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = ks_pkg::addr_t'(idx_reg + 1'b1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        last_reg <= last_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
    end

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CAP_CNT)
    `ASSERT_CLK(a_drop_only_full, clk, rst_n, !dropped_reg || (count_reg == CAP_CNT))
    `ASSERT_CLK(a_shift_pos, clk, rst_n,
        (state_reg != ST_SHIFT) || ((pos_reg != '0) && ({1'b0, pos_reg} <= count_reg)))
    `ASSERT_CLK(a_set_closes, clk, rst_n,
        (res_take && is_final) |=> ((count_reg == '0) && !dropped_reg))

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_sorter_unit.
// ----------------------------------------------------------------------------
// Keys are streamed in as sets closed by last. A sorted shadow store follows
// every accepted key, and each accepted result is checked against the oldest
// predicted word. Short directed sets cover the key extremes, duplicates and
// presorted orders. Random sets of mostly small sizes follow, some filling or
// overflowing the store. Both channels idle in random bursts, and the run ends
// with no idling.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int TAIL_CYCLES        = 200;
    localparam int ITEM_TARGET        = 470;
    localparam int CALM_ITEMS         = 60;
    localparam ks_pkg::key_t KEY_MIN  = {1'b1, {(ks_pkg::KEY_WIDTH-1){1'b0}}};
    localparam ks_pkg::key_t KEY_MAX  = ~KEY_MIN;

    typedef struct {
        ks_pkg::key_t key;
        logic         last;
        bit           drain;
    } key_word_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_stall;
    ks_pkg::key_t key       = '0;
    logic         last      = 1'b0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    ks_pkg::key_t sorted_key;
    logic         final_res;
    logic         overflow;

    key_word_t         key_feed[$];
    ks_pkg::res_word_t sorted_expect[$];
    ks_pkg::key_t      shadow_store[ks_pkg::CAPACITY];
    int                shadow_count = 0;
    bit                shadow_lost  = 1'b0;
    int                mismatches   = 0;
    bit                calm         = 1'b0;
    int                in_gap       = 0;
    int                out_gap      = 0;
    int                in_rate      = 10;
    int                out_rate     = 10;
    int                quiet_cycles = 0;

    key_sorter_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key        (key),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .final_res  (final_res),
        .overflow   (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Insert into the shadow store; on last, queue the whole sorted set.
    task automatic sort_in(ks_pkg::key_t k, logic is_last);
        int pos;
        ks_pkg::res_word_t res;
        if (shadow_count < ks_pkg::CAPACITY)
        begin
            pos = shadow_count;
            while (pos > 0 && shadow_store[pos-1] > k)
            begin
                shadow_store[pos] = shadow_store[pos-1];
                pos--;
            end
            shadow_store[pos] = k;
            shadow_count++;
        end
        else
            shadow_lost = 1'b1;
        if (is_last)
        begin
            for (int i = 0; i < shadow_count; i++)
            begin
                res.key       = shadow_store[i];
                res.final_res = logic'(i == shadow_count - 1);
                res.overflow  = shadow_lost;
                sorted_expect.insert(sorted_expect.size(), res);
            end
            shadow_count = 0;
            shadow_lost  = 1'b0;
        end
    endtask

    task automatic add_key(ks_pkg::key_t k, logic is_last, bit drain);
        key_word_t w;
        w.key   = k;
        w.last  = is_last;
        w.drain = drain;
        key_feed.insert(key_feed.size(), w);
    endtask

    function automatic ks_pkg::key_t rand_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return ks_pkg::key_t'($urandom);
        else if (pick < 8)
            return ks_pkg::key_t'($urandom_range(0, 8)) - ks_pkg::key_t'(4);
        case ($urandom_range(0, 5))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_MIN + ks_pkg::key_t'(1);
            3: return KEY_MAX - ks_pkg::key_t'(1);
            4: return '0;
            default: return '1;
        endcase
    endfunction

    // Idle percentage for one side; zero often, so that some stretches run flat out.
    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return 10;
            default: return 40;
        endcase
    endfunction

    task automatic flag_result(string what, ks_pkg::res_word_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected key %0d final %b overflow %b,",
                     what, want.key, want.final_res, want.overflow,
                     " got key %0d final %b overflow %b",
                     sorted_key, final_res, overflow);
    endtask

    // Driver: feed words from key_feed, hold while stalled.
    always @(posedge clk)
    begin
        key_word_t word;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sort_in(key, last);
            calm = key_feed.size() < CALM_ITEMS;
            if ($urandom_range(0, 99) == 0)
                in_rate = pick_rate();
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0 && !calm)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (key_feed.size() == 0 ||
                         (key_feed[0].drain && sorted_expect.size() != 0))
                    in_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 99) < in_rate)
                begin
                    in_gap = $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end
                else
                begin
                    word = key_feed.pop_front();
                    in_valid <= 1'b1;
                    key      <= word.key;
                    last     <= word.last;
                end
            end
        end
    end

    // Monitor: check each accepted result, drive random stall bursts.
    always @(posedge clk)
    begin
        ks_pkg::res_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (sorted_expect.size() == 0)
                    flag_result("no result pending", '0);
                else
                begin
                    want = sorted_expect.pop_front();
                    if (sorted_key !== want.key || final_res !== want.final_res ||
                        overflow !== want.overflow)
                        flag_result("wrong field", want);
                end
            end
            if ($urandom_range(0, 99) == 0)
                out_rate = pick_rate();
            if (out_gap > 0 && !calm)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < out_rate)
            begin
                out_gap = $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int set_len;
        int set_no;
        bit pause;

        // single-key sets at both extremes
        add_key(KEY_MAX, 1'b1, 1'b0);
        add_key(KEY_MIN, 1'b1, 1'b0);
        // mixed order with duplicates
        add_key('0, 1'b0, 1'b0);
        add_key('1, 1'b0, 1'b0);
        add_key(KEY_MAX, 1'b0, 1'b0);
        add_key(KEY_MIN, 1'b0, 1'b0);
        add_key(ks_pkg::key_t'(1), 1'b0, 1'b0);
        add_key('1, 1'b0, 1'b0);
        add_key(KEY_MIN, 1'b0, 1'b0);
        add_key(KEY_MAX - ks_pkg::key_t'(1), 1'b1, 1'b0);
        // already ascending
        add_key(KEY_MIN, 1'b0, 1'b0);
        add_key(-ks_pkg::key_t'(2), 1'b0, 1'b0);
        add_key(ks_pkg::key_t'(2), 1'b0, 1'b0);
        add_key(KEY_MAX, 1'b1, 1'b0);
        // descending, every key moves the whole store; wait for drain first
        add_key(KEY_MAX, 1'b0, 1'b1);
        add_key(ks_pkg::key_t'(100), 1'b0, 1'b0);
        add_key('0, 1'b0, 1'b0);
        add_key(-ks_pkg::key_t'(100), 1'b0, 1'b0);
        add_key(KEY_MIN, 1'b1, 1'b0);
        // all equal
        add_key(ks_pkg::key_t'(7), 1'b0, 1'b0);
        add_key(ks_pkg::key_t'(7), 1'b0, 1'b0);
        add_key(ks_pkg::key_t'(7), 1'b1, 1'b0);

        set_no = 0;
        while (key_feed.size() < ITEM_TARGET)
        begin
            case (set_no)
                3: set_len = ks_pkg::CAPACITY + 1;
                8: set_len = ks_pkg::CAPACITY;
                12: set_len = $urandom_range(ks_pkg::CAPACITY + 2, ks_pkg::CAPACITY + 8);
                default:
                    case ($urandom_range(0, 19))
                        0: set_len = ks_pkg::CAPACITY;
                        1: set_len = ks_pkg::CAPACITY + 1;
                        2: set_len = $urandom_range(ks_pkg::CAPACITY + 2,
                                                    ks_pkg::CAPACITY + 8);
                        default: set_len = $urandom_range(1, 12);
                    endcase
            endcase
            pause = (set_no == 5) || ($urandom_range(0, 7) == 0);
            for (int j = 0; j < set_len; j++)
                add_key(rand_key(), logic'(j == set_len - 1), pause && j == 0);
            set_no++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!(key_feed.size() == 0 && !in_valid && sorted_expect.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && sorted_expect.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
